// ===== hw/rtl/touch_gesture_classifier_core_assert.svh =====
// Assertion macros shared by the checker of the touch gesture classifier.
// Depends on nothing; each use is written on a line of its own.
`ifndef TOUCH_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("touch gesture classifier check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("touch gesture classifier check failed");

// Next-cycle implication that also covers the reset cycles.
`define TGC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("touch gesture classifier check failed");

`endif

// ===== hw/rtl/tgc_pkg.sv =====
// Package of the touch gesture classifier: types, codes, reset values and the
// coordinate decode function. Depends on nothing.
package tgc_pkg;

    localparam int COORD_W = 12;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0]  INVALID_COUNT = 8'd99;
    localparam logic [COORD_W-1:0] EXIT_X_RESET  = 12'd10;
    localparam logic [COORD_W-1:0] EXIT_Y_RESET  = 12'd430;

    // Configuration register indexes.
    localparam logic CFG_EXIT_X_BELOW = 1'b0;
    localparam logic CFG_EXIT_Y_FROM  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_TAP   = 2'd1,
        ST_SWIPE = 2'd2,
        ST_PINCH = 2'd3
    } gesture_state_t;

    typedef enum logic [2:0] {
        EV_FIRST_TOUCH = 3'd0,
        EV_SWIPE       = 3'd1,
        EV_FIRST_PINCH = 3'd2,
        EV_PINCH       = 3'd3,
        EV_END         = 3'd4,
        EV_EXIT        = 3'd5
    } event_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] point_count;
        logic [BYTE_W-1:0] first_x_high;
        logic [BYTE_W-1:0] first_x_low;
        logic [BYTE_W-1:0] first_y_high;
        logic [BYTE_W-1:0] first_y_low;
        logic [BYTE_W-1:0] second_x_high;
        logic [BYTE_W-1:0] second_x_low;
        logic [BYTE_W-1:0] second_y_high;
        logic [BYTE_W-1:0] second_y_low;
    } snapshot_t;

    typedef struct packed {
        event_kind_t        event_kind;
        logic [1:0]         end_status;
        logic [COORD_W-1:0] pos_x1;
        logic [COORD_W-1:0] pos_y1;
        logic [COORD_W-1:0] pos_x2;
        logic [COORD_W-1:0] pos_y2;
    } result_t;

    // Only the low nibble of the high byte carries coordinate bits.
    function automatic logic [COORD_W-1:0] decode12(input logic [BYTE_W-1:0] hi,
                                                   input logic [BYTE_W-1:0] lo);
        return {hi[3:0], lo};
    endfunction

endpackage

// ===== hw/rtl/tgc_classify.sv =====
// Gesture state register and the classification logic for one snapshot.
// Depends on tgc_pkg.
module tgc_classify (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  tgc_pkg::snapshot_t         snap,
    input  logic [tgc_pkg::COORD_W-1:0] exit_x_below,
    input  logic [tgc_pkg::COORD_W-1:0] exit_y_from,
    output logic                       res_valid,
    output tgc_pkg::result_t           res
);
    import tgc_pkg::*;

    gesture_state_t     state_reg;
    gesture_state_t     state_next;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
    logic               exit_hit;
    logic               is_invalid;
    logic               is_release;
    logic               is_single;

    assign x1 = decode12(snap.first_x_high, snap.first_x_low);
    assign y1 = decode12(snap.first_y_high, snap.first_y_low);
    assign x2 = decode12(snap.second_x_high, snap.second_x_low);
    assign y2 = decode12(snap.second_y_high, snap.second_y_low);

    assign exit_hit   = (x1 < exit_x_below) && (y1 >= exit_y_from);
    assign is_invalid = (snap.point_count == INVALID_COUNT);
    assign is_release = (snap.point_count == '0);
    assign is_single  = (snap.point_count == BYTE_W'(1));

    always_comb begin
        state_next = state_reg;
        if (step) begin
            priority if (is_invalid) begin
                state_next = state_reg;
            end else if (is_release) begin
                state_next = ST_IDLE;
            end else if (is_single) begin
                unique case (state_reg)
                    ST_IDLE:           state_next = exit_hit ? ST_IDLE : ST_TAP;
                    ST_TAP, ST_SWIPE:  state_next = ST_SWIPE;
                    ST_PINCH:          state_next = ST_PINCH;
                    default:           state_next = state_reg;
                endcase
            end else begin
                state_next = ST_PINCH;
            end
        end
    end

    always_comb begin
        res_valid      = 1'b0;
        res            = '0;
        res.event_kind = EV_FIRST_TOUCH;
        priority if (is_invalid) begin
            res_valid = 1'b0;
        end else if (is_release) begin
            res_valid      = (state_reg != ST_IDLE);
            res.event_kind = EV_END;
            res.end_status = 2'(state_reg - 2'd1);
        end else if (is_single) begin
            res.pos_x1 = x1;
            res.pos_y1 = y1;
            unique case (state_reg)
                ST_IDLE: begin
                    res_valid      = 1'b1;
                    res.event_kind = exit_hit ? EV_EXIT : EV_FIRST_TOUCH;
                end
                ST_TAP, ST_SWIPE: begin
                    res_valid      = 1'b1;
                    res.event_kind = EV_SWIPE;
                end
                ST_PINCH: begin
                    res_valid = 1'b0;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end else begin
            res_valid      = 1'b1;
            res.event_kind = (state_reg == ST_IDLE) ? EV_FIRST_PINCH : EV_PINCH;
            res.pos_x1     = x1;
            res.pos_y1     = y1;
            res.pos_x2     = x2;
            res.pos_y2     = y2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/tgc_out_reg.sv =====
// Result register of the touch gesture classifier with its valid flag.
// Depends on tgc_pkg.
module tgc_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  tgc_pkg::result_t res_in,
    input  logic             m_tready,
    output logic             out_valid,
    output tgc_pkg::result_t res_out
);
    import tgc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb begin
        priority if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ===== hw/rtl/touch_gesture_classifier_core.sv =====
// Top level of the touch gesture classifier: input register, configuration
// registers and stream ports. Depends on tgc_pkg, tgc_classify, tgc_out_reg.
//
//   channel   direction  payload
//   s_        in         one register snapshot per item (tdata, 72 bits)
//   m_        out        zero or one gesture event per item (tuser kind, tdata 56 bits)
//   cfg_      in         write-only corner thresholds, index 0 and 1
//
// One item is accepted per cycle while the result register is not stalled by
// m_tready. An accepted item is held in the input register, and its event is
// then loaded into the result register, which drives m_tvalid; no event, no load.
// Reset (aresetn low at a clock edge) empties both registers, returns the
// gesture state to idle and loads the thresholds with 10 and 430.
// While a result waits on m_tready, the input register still takes one more
// item; that item then waits, even when it produces no event, until the result
// register is free or its event leaves.
module touch_gesture_classifier_core (
    input  logic        aclk,
    input  logic        aresetn,
    // point_count, first_x_high, first_x_low, first_y_high, first_y_low,
    // second_x_high, second_x_low, second_y_high, second_y_low (8 bits each)
    input  logic [71:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // end_status [1:0], pos_x1 [13:2], pos_y1 [25:14], pos_x2 [37:26],
    // pos_y2 [49:38], zero fill [55:50]
    output logic [55:0] m_tdata,
    // event_kind [2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wr_data
);
    import tgc_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    snapshot_t          snap_reg;
    snapshot_t          snap_in;
    logic [COORD_W-1:0] exit_x_reg;
    logic [COORD_W-1:0] exit_y_reg;
    logic               out_valid;
    logic               advance;
    logic               s_accept;
    logic               res_valid;
    result_t            res_comb;
    result_t            res_out;

    // Unpack the snapshot bytes, point count in the lowest byte.
    assign snap_in.point_count   = s_tdata[7:0];
    assign snap_in.first_x_high  = s_tdata[15:8];
    assign snap_in.first_x_low   = s_tdata[23:16];
    assign snap_in.first_y_high  = s_tdata[31:24];
    assign snap_in.first_y_low   = s_tdata[39:32];
    assign snap_in.second_x_high = s_tdata[47:40];
    assign snap_in.second_x_low  = s_tdata[55:48];
    assign snap_in.second_y_high = s_tdata[63:56];
    assign snap_in.second_y_low  = s_tdata[71:64];

    // The held snapshot is classified when the result register can take its
    // event, either because it is empty or because its event leaves now.
    assign advance  = in_valid_reg && (!out_valid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        priority if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            snap_reg <= snap_in;
        end
    end

    // Corner thresholds for the exit event.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exit_x_reg <= EXIT_X_RESET;
            exit_y_reg <= EXIT_Y_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_EXIT_X_BELOW: exit_x_reg <= cfg_wr_data;
                CFG_EXIT_Y_FROM:  exit_y_reg <= cfg_wr_data;
                default:          exit_x_reg <= exit_x_reg;
            endcase
        end
    end

    tgc_classify u_classify (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .snap         (snap_reg),
        .exit_x_below (exit_x_reg),
        .exit_y_from  (exit_y_reg),
        .res_valid    (res_valid),
        .res          (res_comb)
    );

    tgc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .res_in    (res_comb),
        .m_tready  (m_tready),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = res_out.event_kind;
    assign m_tdata  = {6'b0, res_out.pos_y2, res_out.pos_x2, res_out.pos_y1,
                       res_out.pos_x1, res_out.end_status};

endmodule

// ===== hw/rtl/tgc_checker.sv =====
// Port-level checker for the touch gesture classifier and its bind statement.
// Depends on tgc_pkg and touch_gesture_classifier_core_assert.svh.
`include "touch_gesture_classifier_core_assert.svh"

module tgc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tvalid,
    input logic        m_tready
);
    import tgc_pkg::*;

    // A stalled event keeps its kind and payload.
    `TGC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // No event is offered in the cycle after reset.
    `TGC_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // A gesture end carries no coordinates.
    `TGC_ASSERT_IMPL(a_end_no_pos, aclk, aresetn, m_tvalid && (m_tuser == EV_END), m_tdata[55:2] == '0)

    // Only a gesture end reports a status, and only pinch events a second point.
    `TGC_ASSERT_IMPL(a_status_pos2, aclk, aresetn, m_tvalid && (m_tuser != EV_END), (m_tdata[1:0] == 2'b00) && ((m_tuser == EV_FIRST_PINCH) || (m_tuser == EV_PINCH) || (m_tdata[49:26] == '0)))

endmodule

bind touch_gesture_classifier_core tgc_checker u_tgc_checker (.*);

// ===== test/touch_gesture_classifier_core_test.sv =====
// Self-checking testbench for touch_gesture_classifier_core: directed and random
// touch snapshots with a built-in gesture predictor. Depends on tgc_pkg and the RTL.
`timescale 1ns / 100ps

module touch_gesture_classifier_core_test;
    import tgc_pkg::*;

    // End status codes carried in tdata on a gesture end.
    localparam logic [1:0] END_TAP   = 2'd0;
    localparam logic [1:0] END_SWIPE = 2'd1;
    localparam logic [1:0] END_PINCH = 2'd2;

    // Bound for the watchdog; ample for the slowest legal run.
    localparam int unsigned CYCLE_LIMIT = 500000;
    // Two register stages sit between an accepted item and its result.
    localparam int DRAIN_CYCLES = 8;

    logic        aclk;
    logic        aresetn;
    logic [71:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [11:0] cfg_wr_data;

    touch_gesture_classifier_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predictor state: the gesture tracked so far and the exit corner thresholds.
    gesture_state_t model_state;
    logic [11:0]    exit_x_model;
    logic [11:0]    exit_y_model;

    // Events predicted for accepted snapshots, oldest first.
    result_t pending_events[$];
    result_t oldest_event;

    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          snapshots_sent;
    int          invalid_sent;
    int          events_checked;
    int          mismatch_count;
    int          kind_seen[6];
    int unsigned cycle_count;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The watchdog ends a run that hangs on a handshake.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("touch_gesture_classifier_core verification failed");
            $finish;
        end
    end

    task automatic report_failure(input string what);
        if (mismatch_count < 40)
            $display("ERROR cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_failure($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Gesture predictor. It is called once per accepted snapshot, in order of
    // acceptance, and queues the event that the snapshot must produce, if any.
    task automatic classify_snapshot(input snapshot_t snap);
        result_t     ev;
        bit          fires;
        logic [11:0] x1, y1, x2, y2;
        ev    = '0;
        fires = 1'b1;
        x1 = {snap.first_x_high[3:0], snap.first_x_low};
        y1 = {snap.first_y_high[3:0], snap.first_y_low};
        x2 = {snap.second_x_high[3:0], snap.second_x_low};
        y2 = {snap.second_y_high[3:0], snap.second_y_low};
        if (snap.point_count == INVALID_COUNT) begin
            // An invalid snapshot leaves everything untouched.
            fires = 1'b0;
        end else if (snap.point_count == 8'd0) begin
            // Release: only a gesture in progress reports its final status.
            ev.event_kind = EV_END;
            case (model_state)
                ST_TAP:   ev.end_status = END_TAP;
                ST_SWIPE: ev.end_status = END_SWIPE;
                ST_PINCH: ev.end_status = END_PINCH;
                default:  fires = 1'b0;
            endcase
            model_state = ST_IDLE;
        end else if (snap.point_count == 8'd1) begin
            ev.pos_x1 = x1;
            ev.pos_y1 = y1;
            case (model_state)
                ST_IDLE: begin
                    // A first touch inside the corner asks for exit and keeps idle.
                    if (x1 < exit_x_model && y1 >= exit_y_model) begin
                        ev.event_kind = EV_EXIT;
                    end else begin
                        ev.event_kind = EV_FIRST_TOUCH;
                        model_state   = ST_TAP;
                    end
                end
                ST_TAP, ST_SWIPE: begin
                    ev.event_kind = EV_SWIPE;
                    model_state   = ST_SWIPE;
                end
                default: fires = 1'b0;  // one finger left during a pinch is ignored
            endcase
        end else begin
            // Two or more points: the first two make a pinch.
            ev.event_kind = (model_state == ST_IDLE) ? EV_FIRST_PINCH : EV_PINCH;
            ev.pos_x1     = x1;
            ev.pos_y1     = y1;
            ev.pos_x2     = x2;
            ev.pos_y2     = y2;
            model_state   = ST_PINCH;
        end
        if (fires)
            pending_events.push_back(ev);
    endtask

    // The upper nibble of every high byte is filler that the block must ignore.
    function automatic snapshot_t make_snap(input logic [7:0] count,
                                            input logic [11:0] x1, input logic [11:0] y1,
                                            input logic [11:0] x2, input logic [11:0] y2,
                                            input logic [15:0] filler);
        snapshot_t snap;
        snap.point_count   = count;
        snap.first_x_high  = {filler[3:0], x1[11:8]};
        snap.first_x_low   = x1[7:0];
        snap.first_y_high  = {filler[7:4], y1[11:8]};
        snap.first_y_low   = y1[7:0];
        snap.second_x_high = {filler[11:8], x2[11:8]};
        snap.second_x_low  = x2[7:0];
        snap.second_y_high = {filler[15:12], y2[11:8]};
        snap.second_y_low  = y2[7:0];
        return snap;
    endfunction

    function automatic logic [11:0] near_value(input int threshold);
        int v;
        v = threshold + int'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    // Random coordinates, with a share of first points placed around the corner
    // thresholds so that exit decisions hit both sides of each bound.
    function automatic snapshot_t random_snap(input logic [7:0] count);
        logic [11:0] x1, y1;
        x1 = 12'($urandom);
        y1 = 12'($urandom);
        if ($urandom_range(99) < 30) begin
            x1 = ($urandom_range(1) == 0) ? near_value(exit_x_model)
                                          : 12'($urandom_range(exit_x_model));
            y1 = near_value(exit_y_model);
        end
        return make_snap(count, x1, y1, 12'($urandom), 12'($urandom), 16'($urandom));
    endfunction

    // Sends one item, with random idle cycles ahead of it. Valid stays high after
    // the handshake; at the next falling edge an idle cycle lowers it or the next item takes its place.
    task automatic send_snapshot(input snapshot_t snap);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {snap.second_y_low, snap.second_y_high, snap.second_x_low,
                     snap.second_x_high, snap.first_y_low, snap.first_y_high,
                     snap.first_x_low, snap.first_x_high, snap.point_count};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        classify_snapshot(snap);
        if (snap.point_count == INVALID_COUNT)
            invalid_sent++;
        else
            snapshots_sent++;
    endtask

    // Holds the sender off until every predicted event has been seen, then lets
    // extra cycles pass for snapshots that are still in flight but produce nothing.
    task automatic wait_quiet(input int extra_cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge aclk);
        repeat (extra_cycles)
            @(posedge aclk);
    endtask

    task automatic write_threshold(input logic index, input logic [11:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= index;
        cfg_wr_data <= value;
        if (index == CFG_EXIT_X_BELOW)
            exit_x_model = value;
        else
            exit_y_model = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random gestures: mostly a touch-down, moves or pinches, then a release,
    // with invalid snapshots and arbitrary counts mixed in.
    task automatic run_random(input int target, input int idle_pct, input int stall_pct);
        int         start;
        int         steps;
        int         r;
        bit         paused;
        logic [7:0] count;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start  = snapshots_sent;
        paused = 1'b0;
        while (snapshots_sent - start < target) begin
            // Halfway through, the sender waits once for every result to come back.
            if (!paused && snapshots_sent - start >= target / 2) begin
                wait_quiet(0);
                paused = 1'b1;
            end
            if ($urandom_range(99) < 12) begin
                send_snapshot(random_snap(8'($urandom)));
            end else begin
                steps = $urandom_range(1, 8);
                for (int k = 0; k < steps; k++) begin
                    r = $urandom_range(99);
                    if (k == 0)
                        count = (r < 80) ? 8'd1 : 8'($urandom_range(2, 3));
                    else if (r < 60)
                        count = 8'd1;
                    else if (r < 85)
                        count = 8'($urandom_range(2, 5));
                    else if (r < 93)
                        count = INVALID_COUNT;
                    else if (r < 97)
                        count = 8'd0;
                    else
                        count = 8'($urandom_range(6, 255));
                    send_snapshot(random_snap(count));
                end
                if ($urandom_range(99) < 85)
                    send_snapshot(random_snap(8'd0));
            end
        end
    endtask

    // Every kind of event and ignored snapshot, with the reset thresholds of 10
    // and 430, bounds exactly on the corner edges and all-ones and all-zeros bytes.
    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_snapshot(make_snap(8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));   // idle release
        send_snapshot(make_snap(INVALID_COUNT, 12'd9, 12'd430, 0, 0, 16'hffff));
        send_snapshot(make_snap(8'd1, 12'd9, 12'd430, 0, 0, 16'hffff));        // exit, on edge
        send_snapshot(make_snap(8'd1, 12'd0, 12'd4095, 0, 0, 16'h0000));       // exit
        send_snapshot(make_snap(8'd1, 12'd10, 12'd430, 0, 0, 16'h5a5a));       // x on bound
        send_snapshot(make_snap(INVALID_COUNT, 12'd1, 12'd1, 0, 0, 16'hffff)); // tap kept
        send_snapshot(make_snap(8'd0, 12'd0, 12'd0, 0, 0, 16'hffff));          // end of tap
        send_snapshot(make_snap(8'd1, 12'd9, 12'd429, 0, 0, 16'ha5a5));        // y below bound
        send_snapshot(make_snap(8'd1, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hffff));
        send_snapshot(make_snap(8'd1, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));  // swipe again
        send_snapshot(make_snap(8'd0, 12'd7, 12'd7, 12'd7, 12'd7, 16'h0000));  // end of swipe
        send_snapshot(make_snap(8'd2, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hffff));
        send_snapshot(make_snap(8'd1, 12'd100, 12'd200, 0, 0, 16'h0000));      // pinch, 1 point
        send_snapshot(make_snap(INVALID_COUNT, 12'd5, 12'd500, 0, 0, 16'h0000));
        send_snapshot(make_snap(8'd255, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_snapshot(make_snap(8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));  // end of pinch
        send_snapshot(make_snap(8'd1, 12'd2048, 12'd1024, 0, 0, 16'h1234));
        send_snapshot(make_snap(8'd3, 12'd1, 12'd2, 12'd3, 12'd4, 16'h8421));  // tap to pinch
        send_snapshot(make_snap(8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_snapshot(make_snap(8'd1, 12'd1, 12'd1, 0, 0, 16'h0000));
        send_snapshot(make_snap(8'd1, 12'd3000, 12'd5, 0, 0, 16'h0000));       // swipe
        send_snapshot(make_snap(8'd100, 12'd11, 12'd22, 12'd33, 12'd44, 16'h0f0f));
        send_snapshot(make_snap(8'd98, 12'd55, 12'd66, 12'd77, 12'd88, 16'hf0f0));
        send_snapshot(make_snap(8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));
        send_snapshot(make_snap(8'd1, 12'd5, 12'd1000, 0, 0, 16'h0000));       // exit
        send_snapshot(make_snap(8'd2, 12'd5, 12'd1000, 12'd6, 12'd6, 16'h0000)); // first pinch
        send_snapshot(make_snap(8'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'h0000));
    endtask

    // Both thresholds are moved through their extremes and a random setting,
    // each followed by random gestures; the reset values are restored at the end.
    task automatic test_thresholds();
        logic [11:0] x_settings[5];
        logic [11:0] y_settings[5];
        x_settings = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'($urandom)};
        y_settings = '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'($urandom)};
        for (int i = 0; i < 5; i++) begin
            wait_quiet(DRAIN_CYCLES);
            write_threshold(CFG_EXIT_X_BELOW, x_settings[i]);
            write_threshold(CFG_EXIT_Y_FROM, y_settings[i]);
            run_random(60, $urandom_range(50), $urandom_range(50));
        end
        wait_quiet(DRAIN_CYCLES);
        write_threshold(CFG_EXIT_X_BELOW, EXIT_X_RESET);
        write_threshold(CFG_EXIT_Y_FROM, EXIT_Y_RESET);
    endtask

    // Random gestures under each idling pattern of the two sides.
    task automatic test_handshake_idling();
        run_random(400, 0, 0);
        run_random(400, 76, 0);
        run_random(400, 0, 76);
        run_random(400, 11, 11);
    endtask

    // Result side: ready is redrawn every cycle, and each accepted event is
    // compared with the oldest prediction.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                report_failure($sformatf("event of kind %0d with none expected", m_tuser));
            end else begin
                oldest_event = pending_events.pop_front();
                check_field("event_kind", m_tuser, oldest_event.event_kind);
                check_field("end_status", m_tdata[1:0], oldest_event.end_status);
                check_field("pos_x1", m_tdata[13:2], oldest_event.pos_x1);
                check_field("pos_y1", m_tdata[25:14], oldest_event.pos_y1);
                check_field("pos_x2", m_tdata[37:26], oldest_event.pos_x2);
                check_field("pos_y2", m_tdata[49:38], oldest_event.pos_y2);
            end
            events_checked++;
            if (m_tuser < 3'd6)
                kind_seen[m_tuser]++;
        end
    end

    initial begin
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        m_tready           = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_addr           = CFG_EXIT_X_BELOW;
        cfg_wr_data        = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        snapshots_sent     = 0;
        invalid_sent       = 0;
        events_checked     = 0;
        mismatch_count     = 0;
        kind_seen          = '{default: 0};
        model_state        = ST_IDLE;
        exit_x_model       = EXIT_X_RESET;
        exit_y_model       = EXIT_Y_RESET;

        repeat (12)
            @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_thresholds();
        test_handshake_idling();

        wait_quiet(DRAIN_CYCLES);
        if (pending_events.size() != 0)
            report_failure($sformatf("%0d events never arrived", pending_events.size()));

        $display("Run summary: %0d snapshots plus %0d invalid ones, %0d events checked",
                 snapshots_sent, invalid_sent, events_checked);
        $display("  first touch %0d, swipe %0d, first pinch %0d, pinch %0d, end %0d, exit %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5]);
        if (mismatch_count == 0) begin
            $display("touch_gesture_classifier_core verification clean");
        end else begin
            $display("touch_gesture_classifier_core verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tgc_pkg.sv
hw/rtl/tgc_classify.sv
hw/rtl/tgc_out_reg.sv
hw/rtl/touch_gesture_classifier_core.sv
hw/rtl/tgc_checker.sv
test/touch_gesture_classifier_core_test.sv
